@@ rtl/hbe_pkg.sv @@
`default_nettype none

package hbe_pkg;

  // store geometry and field widths
  localparam int MAX_LEVELS = 1024;
  localparam int BIN_AW     = $clog2(MAX_LEVELS);
  localparam int CNT_W      = 32;
  localparam int DATA_W     = 32;
  localparam int LVL_W      = 11;
  localparam int QUO_W      = 11;
  localparam int PROD_W     = DATA_W + LVL_W;
  localparam int CFG_IDX_W  = 2;

  // op codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result classes
  localparam logic [1:0] CLS_IN    = 2'd0;
  localparam logic [1:0] CLS_UNDER = 2'd1;
  localparam logic [1:0] CLS_OVER  = 2'd2;
  localparam logic [1:0] CLS_UNDEF = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS   = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] sample;
    logic                     undefined;
    logic [BIN_AW-1:0]        bin_select;
  } hbe_in_t;

  typedef struct packed {
    logic [1:0]        bin_class;
    logic [BIN_AW-1:0] bin_index;
    logic [CNT_W-1:0]  bin_count;
    logic [CNT_W-1:0]  under_count;
    logic [CNT_W-1:0]  over_count;
    logic [CNT_W-1:0]  undefined_count;
  } hbe_out_t;

  // status from the bin divider
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } hbe_div_sts_t;

endpackage

`default_nettype wire

@@ rtl/hbe_div.sv @@
`default_nettype none

module hbe_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hbe_pkg::DATA_W-1:0]   num,
  input  logic [hbe_pkg::DATA_W-1:0]   den,
  input  logic [hbe_pkg::LVL_W-1:0]    lvl,
  output hbe_pkg::hbe_div_sts_t        sts
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_ITER = 2'd2;
  localparam int STEP_W = $clog2(hbe_pkg::QUO_W);

  logic [1:0]                  phase_r;
  logic [hbe_pkg::DATA_W-1:0]  num_r;
  logic [hbe_pkg::DATA_W-1:0]  den_r;
  logic [hbe_pkg::LVL_W-1:0]   lvl_r;
  logic [hbe_pkg::DATA_W-1:0]  rem_r;
  logic [hbe_pkg::QUO_W-1:0]   low_r;
  logic [hbe_pkg::QUO_W-1:0]   q_r;
  logic [STEP_W-1:0]           step_r;
  logic                        done_r;

  logic [hbe_pkg::PROD_W-1:0]  prod;
  logic [hbe_pkg::DATA_W:0]    trial;
  logic [hbe_pkg::DATA_W:0]    diff;
  logic                        ge;

  // scaled numerator, then one quotient bit per cycle
  assign prod  = hbe_pkg::PROD_W'(num_r) * hbe_pkg::PROD_W'(lvl_r);
  assign trial = {rem_r, low_r[hbe_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      // completion flag for the cycle after the last quotient bit
      done_r <= !start && (phase_r == D_ITER)
                && (step_r == STEP_W'(hbe_pkg::QUO_W - 1));
      if (start) begin
        num_r   <= num;
        den_r   <= den;
        lvl_r   <= lvl;
        phase_r <= D_MUL;
      end else begin
        unique case (phase_r)
          D_MUL: begin
            // quotient fits QUO_W bits, so the top part is already below den
            rem_r   <= prod[hbe_pkg::PROD_W-1:hbe_pkg::QUO_W];
            low_r   <= prod[hbe_pkg::QUO_W-1:0];
            q_r     <= '0;
            step_r  <= '0;
            phase_r <= D_ITER;
          end
          D_ITER: begin
            rem_r  <= ge ? diff[hbe_pkg::DATA_W-1:0] : trial[hbe_pkg::DATA_W-1:0];
            low_r  <= {low_r[hbe_pkg::QUO_W-2:0], 1'b0};
            q_r    <= {q_r[hbe_pkg::QUO_W-2:0], ge};
            step_r <= step_r + STEP_W'(1);
            if (step_r == STEP_W'(hbe_pkg::QUO_W - 1)) begin
              phase_r <= D_IDLE;
            end
          end
          default: phase_r <= D_IDLE;
        endcase
      end
    end
  end

  assign sts.done = done_r;
  assign sts.quot = q_r;

`ifndef ASSERT_OFF
  // remainder stays below the divisor through the iterations
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == D_ITER |-> rem_r < den_r)
    else $error("hbe_div: remainder not below divisor");

  // sample never lies above the upper limit, so the bin never exceeds levels
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> q_r <= lvl_r)
    else $error("hbe_div: quotient above level count");

  // a new division only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> phase_r == D_IDLE)
    else $error("hbe_div: start while busy");
`endif

endmodule

`default_nettype wire

@@ rtl/histogram_binning_engine.sv @@
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   hbe_in_t   (op, sample, undefined, bin_select)
// out_      output     out_valid / out_stall hbe_out_t  (class, index, count, three totals)
// cfg_      input      cfg_valid / cfg_ready cfg_index selects register, cfg_data value
//
// one item at a time: in-range add runs classify, multiply, an 11-bit quotient in the serial
//   divider, bin read, write back; degenerate-span add skips the divider, read starts at bin
//   read, under/over stop at classify, undefined and unused op go to output, clear sweeps
// bin store is a 1024-entry ram with one write port and one registered read port;
//   each clear op and reset run a zeroing sweep of all 1024 entries with in_stall high
// a finished result sits in the output register until out_stall drops; the next item
//   is taken while it waits

module histogram_binning_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hbe_pkg::hbe_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hbe_pkg::hbe_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbe_pkg::DATA_W-1:0]          cfg_data
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int DW  = hbe_pkg::DATA_W;
  localparam int LW  = hbe_pkg::LVL_W;
  localparam int AW  = hbe_pkg::BIN_AW;
  localparam int CW  = hbe_pkg::CNT_W;

  // configuration registers
  logic signed [DW-1:0] lower_r;
  logic signed [DW-1:0] upper_r;
  logic [LW-1:0]        level_r;
  logic                 abs_r;

  // control and item state
  logic [2:0]           state_r;
  logic [AW-1:0]        sweep_addr_r;
  logic                 sweep_reply_r;
  logic [1:0]           op_r;
  logic signed [DW:0]   v_r;
  logic [AW-1:0]        addr_r;
  logic [1:0]           cls_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        under_r;
  logic [CW-1:0]        over_r;
  logic [CW-1:0]        undef_r;
  logic                 out_valid_r;
  hbe_pkg::hbe_out_t    out_data_r;

  // bin store
  logic [CW-1:0]        mem [hbe_pkg::MAX_LEVELS];
  logic [CW-1:0]        rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CW-1:0]        mem_wdata;
  logic [CW-1:0]        bumped;

  // combinational helpers
  logic [LW-1:0]        lvl_use;
  logic [LW-1:0]        lvl_max;
  logic [LW-1:0]        deg_half;
  logic [LW-1:0]        deg_bin;
  logic [LW-1:0]        div_bin;
  logic signed [DW:0]   lo_x;
  logic signed [DW:0]   hi_x;
  logic signed [DW:0]   num_x;
  logic signed [DW:0]   den_x;
  logic signed [DW:0]   s_x;
  logic signed [DW:0]   s_abs;
  logic                 is_under;
  logic                 is_over;
  logic                 div_start;
  logic                 accept;
  hbe_pkg::hbe_div_sts_t div_sts;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    sat_inc = (&c) ? c : c + CW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= DW'(65536);
      level_r <= LW'(256);
      abs_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hbe_pkg::CFG_LOWER: lower_r <= cfg_data;
        hbe_pkg::CFG_UPPER: upper_r <= cfg_data;
        hbe_pkg::CFG_LEVEL: level_r <= cfg_data[LW-1:0];
        hbe_pkg::CFG_ABS:   abs_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // levels in use and bin clamps
  always_comb begin
    if (level_r == '0) begin
      lvl_use = LW'(1);
    end else if (level_r > LW'(hbe_pkg::MAX_LEVELS)) begin
      lvl_use = LW'(hbe_pkg::MAX_LEVELS);
    end else begin
      lvl_use = level_r;
    end
    lvl_max  = lvl_use - LW'(1);
    deg_half = (lvl_use >> 1) + LW'(1);
    deg_bin  = (deg_half > lvl_max) ? lvl_max : deg_half;
    div_bin  = (div_sts.quot > lvl_max) ? lvl_max : div_sts.quot;
  end

  // sample conditioning and range checks
  assign s_x      = {in_data.sample[DW-1], in_data.sample};
  assign s_abs    = (abs_r && in_data.sample[DW-1]) ? -s_x : s_x;
  assign lo_x     = {lower_r[DW-1], lower_r};
  assign hi_x     = {upper_r[DW-1], upper_r};
  assign is_under = (v_r < lo_x);
  assign is_over  = (v_r > hi_x);
  assign num_x    = v_r - lo_x;
  assign den_x    = hi_x - lo_x;
  assign div_start = (state_r == S_CLASS) && !is_under && !is_over
                     && (lower_r != upper_r);

  hbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x[DW-1:0]),
    .den   (den_x[DW-1:0]),
    .lvl   (lvl_use),
    .sts   (div_sts)
  );

  // store write port: zeroing sweep or read-modify-write of one bin
  assign bumped    = sat_inc(rdata_r);
  assign mem_we    = (state_r == S_SWEEP) || (state_r == S_MOD && op_r == hbe_pkg::OP_ADD);
  assign mem_waddr = (state_r == S_SWEEP) ? sweep_addr_r : addr_r;
  assign mem_wdata = (state_r == S_SWEEP) ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      sweep_addr_r  <= '0;
      sweep_reply_r <= 1'b0;
      addr_r        <= '0;
      under_r       <= '0;
      over_r        <= '0;
      undef_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // result register drains on a transfer unless refilled below
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          sweep_addr_r <= sweep_addr_r + AW'(1);
          if (&sweep_addr_r) begin
            state_r <= sweep_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r   <= in_data.op;
            v_r    <= s_abs;
            cnt_r  <= '0;
            unique case (in_data.op)
              hbe_pkg::OP_CLEAR: begin
                cls_r         <= hbe_pkg::CLS_IN;
                addr_r        <= '0;
                under_r       <= '0;
                over_r        <= '0;
                undef_r       <= '0;
                sweep_addr_r  <= '0;
                sweep_reply_r <= 1'b1;
                state_r       <= S_SWEEP;
              end
              hbe_pkg::OP_ADD: begin
                addr_r <= '0;
                if (in_data.undefined) begin
                  undef_r <= sat_inc(undef_r);
                  cls_r   <= hbe_pkg::CLS_UNDEF;
                  state_r <= S_DONE;
                end else begin
                  cls_r   <= hbe_pkg::CLS_IN;
                  state_r <= S_CLASS;
                end
              end
              hbe_pkg::OP_READ: begin
                cls_r   <= hbe_pkg::CLS_IN;
                addr_r  <= in_data.bin_select;
                state_r <= S_READ;
              end
              default: begin
                cls_r   <= hbe_pkg::CLS_IN;
                addr_r  <= '0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_CLASS: begin
          if (is_under) begin
            under_r <= sat_inc(under_r);
            cls_r   <= hbe_pkg::CLS_UNDER;
            state_r <= S_DONE;
          end else if (is_over) begin
            over_r  <= sat_inc(over_r);
            cls_r   <= hbe_pkg::CLS_OVER;
            state_r <= S_DONE;
          end else if (lower_r == upper_r) begin
            addr_r  <= deg_bin[AW-1:0];
            state_r <= S_READ;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            addr_r  <= div_bin[AW-1:0];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          cnt_r   <= (op_r == hbe_pkg::OP_ADD) ? bumped : rdata_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.bin_class       <= cls_r;
            out_data_r.bin_index       <= addr_r;
            out_data_r.bin_count       <= cnt_r;
            out_data_r.under_count     <= under_r;
            out_data_r.over_count      <= over_r;
            out_data_r.undefined_count <= undef_r;
            sweep_reply_r              <= 1'b0;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // an accepted item keeps the input side busy in the cycle after the transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("hbe: input not stalled after a transfer");

  // divider results only arrive while the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == S_DIV)
    else $error("hbe: divider done outside wait state");

  // a new result is only loaded from the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("hbe: result loaded outside completion state");
`endif

endmodule

`default_nettype wire
